FILE: hdl/rot_pkg.sv
// Shared types and constants for the resource ownership table.
package rot_pkg;

    localparam int ROT_ENTRIES   = 256;
    localparam int ROT_KIND_BITS = 4;
    localparam int ROT_KEY_BITS  = 32;
    localparam int ROT_NUM_BITS  = 32;
    localparam int ROT_CNT_BITS  = 32;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_TRANSFER   = 2'd1,
        OP_UNREGISTER = 2'd2,
        OP_VERIFY     = 2'd3
    } rot_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_FULL     = 2'd2,
        ST_MISSING  = 2'd3
    } rot_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } rot_fsm_t;

    typedef struct packed {
        rot_op_t                    opcode;
        logic [ROT_KEY_BITS-1:0]    resource_key;
        logic [ROT_KIND_BITS-1:0]   owner_kind;
        logic [ROT_NUM_BITS-1:0]    owner_number;
    } rot_in_t;

    typedef struct packed {
        rot_status_t                status;
        logic                       owner_match;
        logic [ROT_CNT_BITS-1:0]    violations;
    } rot_out_t;

    // A request travelling down the row of slots.
    typedef struct packed {
        logic                       active;
        logic                       done;
        logic                       match;
        rot_op_t                    op;
        logic [ROT_KEY_BITS-1:0]    key;
        logic [ROT_KIND_BITS-1:0]   kind;
        logic [ROT_NUM_BITS-1:0]    number;
    } rot_token_t;

endpackage

FILE: hdl/rot_cell.sv
// One table slot: holds an entry and acts on the request passing through it.
module rot_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  rot_pkg::rot_token_t tok_in,
    output rot_pkg::rot_token_t tok_out
);
    import rot_pkg::*;

    logic                     valid_reg, valid_next;
    logic [ROT_KEY_BITS-1:0]  key_reg, key_next;
    logic [ROT_KIND_BITS-1:0] kind_reg, kind_next;
    logic [ROT_NUM_BITS-1:0]  number_reg, number_next;
    rot_token_t               tok_reg, tok_next;
    logic                     hit;

    always_comb begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        kind_next   = kind_reg;
        number_next = number_reg;
        tok_next    = tok_in;
        hit         = 1'b0;

        if (tok_in.active && !tok_in.done) begin
            if (tok_in.op == OP_REGISTER) begin
                hit = !valid_reg;
            end else begin
                hit = valid_reg && (key_reg == tok_in.key);
            end
        end

        if (hit) begin
            tok_next.done = 1'b1;
            case (tok_in.op)
                OP_REGISTER: begin
                    valid_next  = 1'b1;
                    key_next    = tok_in.key;
                    kind_next   = tok_in.kind;
                    number_next = tok_in.number;
                end
                OP_TRANSFER: begin
                    kind_next   = tok_in.kind;
                    number_next = tok_in.number;
                end
                OP_UNREGISTER: begin
                    valid_next = 1'b0;
                end
                OP_VERIFY: begin
                    tok_next.match = (kind_reg == tok_in.kind) &&
                                     (number_reg == tok_in.number);
                end
                default: begin
                    tok_next.done = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        kind_reg   <= kind_next;
        number_reg <= number_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: hdl/resource_ownership_table_unit.sv
// Top level of the resource ownership table: control, counter and the row of slots.
//
// The table is a row of ENTRIES slot cells. An accepted request enters the first
// cell and moves one cell per clock; the lowest free slot (register) or the lowest
// valid slot with a matching key (transfer, unregister, verify) acts on it, and the
// cells after it let it pass. The result leaves the last cell, and the block takes
// one request at a time. While disabled, a request is answered without touching
// the table. A finished result waits in the output register and the next request
// may be accepted meanwhile. Reset clears all slots and the violation counter at
// once; no clearing pass is needed.
module resource_ownership_table_unit #(
    parameter int ENTRIES = rot_pkg::ROT_ENTRIES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  rot_pkg::rot_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rot_pkg::rot_out_t m_data
);
    import rot_pkg::*;

    rot_fsm_t                 state_reg, state_next;
    logic                     enabled_reg;
    logic [ROT_CNT_BITS-1:0]  count_reg, count_next;
    rot_status_t              status_reg, status_next;
    logic                     match_reg, match_next;
    logic                     m_valid_reg, m_valid_next;
    rot_out_t                 m_data_reg, m_data_next;
    rot_token_t               launch_reg, launch_next;
    rot_token_t               tok [ENTRIES+1];
    rot_token_t               tail;
    logic                     s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == FSM_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign tail      = tok[ENTRIES];
    assign tok[0]    = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            rot_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        match_next   = match_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        launch_next        = launch_reg;
        launch_next.active = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    if (enabled_reg) begin
                        launch_next.active = 1'b1;
                        launch_next.done   = 1'b0;
                        launch_next.match  = 1'b0;
                        launch_next.op     = s_data.opcode;
                        launch_next.key    = s_data.resource_key;
                        launch_next.kind   = s_data.owner_kind;
                        launch_next.number = s_data.owner_number;
                        state_next         = FSM_SCAN;
                    end else begin
                        status_next = ST_DISABLED;
                        match_next  = 1'b0;
                        state_next  = FSM_DONE;
                    end
                end
            end
            FSM_SCAN: begin
                if (tail.active) begin
                    match_next = tail.match;
                    if (tail.done) begin
                        status_next = ST_OK;
                    end else if (tail.op == OP_REGISTER) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_MISSING;
                        // A lookup that misses counts as a violation, a failed free does not.
                        if (tail.op == OP_TRANSFER || tail.op == OP_VERIFY) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.owner_match = match_reg;
                    m_data_next.violations  = count_reg;
                    state_next              = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            enabled_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            launch_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            launch_reg  <= launch_next;
            if (cfg_valid && cfg_ready) begin
                enabled_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        match_reg  <= match_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // A request can only leave the row while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tail.active |-> state_reg == FSM_SCAN)
        else $error("request left the slot row outside of a scan");

    // A request enters the row only in the cycle after an enabled transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg.active |-> $past(s_valid && s_ready && enabled_reg))
        else $error("request launched without an accepted transaction");

    // The violation counter moves only when a request finishes its scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !tail.active |=> $stable(count_reg))
        else $error("violation counter changed outside a scan result");

    // A new result is presented only from the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !(m_valid_reg && !m_ready)) |-> state_reg == FSM_DONE)
        else $error("result loaded outside the result state");

    // Only a disabled block reports the not-enabled status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SCAN) |-> status_next != ST_DISABLED || !tail.active)
        else $error("scan produced a not-enabled status");
`endif

endmodule

FILE: dv/resource_ownership_table_unit_tb.sv
// Self-checking testbench for the resource ownership table unit.
`timescale 1ns / 1ps

module resource_ownership_table_unit_tb;
    import rot_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int KEY_POOL_SIZE = 32;
    localparam int KIND_MAX = (1 << ROT_KIND_BITS) - 1;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic s_valid;
    logic s_ready;
    rot_in_t s_data;
    logic m_valid;
    logic m_ready;
    rot_out_t m_data;

    // Shadow copy of the table, the counter and the enable flag.
    logic table_enabled;
    bit slot_used[ROT_ENTRIES];
    logic [ROT_KEY_BITS-1:0] slot_res_key[ROT_ENTRIES];
    logic [ROT_KIND_BITS-1:0] slot_kind[ROT_ENTRIES];
    logic [ROT_NUM_BITS-1:0] slot_num[ROT_ENTRIES];
    logic [ROT_CNT_BITS-1:0] violation_tally;

    rot_out_t expected_results[$];
    rot_out_t oldest_expected;
    logic [ROT_KEY_BITS-1:0] key_pool[KEY_POOL_SIZE];

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int status_seen[4];

    resource_ownership_table_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int lowest_slot_with_key(input logic [ROT_KEY_BITS-1:0] key);
        for (int i = 0; i < ROT_ENTRIES; i++) begin
            if (slot_used[i] && slot_res_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic rot_out_t apply_table_op(input rot_in_t req);
        rot_out_t res;
        int hit;
        res.status = ST_OK;
        res.owner_match = 1'b0;
        hit = -1;
        if (!table_enabled) begin
            res.status = ST_DISABLED;
        end else if (req.opcode == OP_REGISTER) begin
            for (int i = 0; i < ROT_ENTRIES && hit < 0; i++) begin
                if (!slot_used[i]) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                res.status = ST_FULL;
            end else begin
                slot_used[hit] = 1'b1;
                slot_res_key[hit] = req.resource_key;
                slot_kind[hit] = req.owner_kind;
                slot_num[hit] = req.owner_number;
            end
        end else begin
            hit = lowest_slot_with_key(req.resource_key);
            if (hit < 0) begin
                res.status = ST_MISSING;
                // A missing resource on unregister is not a violation.
                if (req.opcode != OP_UNREGISTER) begin
                    violation_tally = violation_tally + 1'b1;
                end
            end else begin
                case (req.opcode)
                    OP_TRANSFER: begin
                        slot_kind[hit] = req.owner_kind;
                        slot_num[hit] = req.owner_number;
                    end
                    OP_UNREGISTER: begin
                        slot_used[hit] = 1'b0;
                    end
                    default: begin
                        res.owner_match = (slot_kind[hit] == req.owner_kind) &&
                                          (slot_num[hit] == req.owner_number);
                    end
                endcase
            end
        end
        res.violations = violation_tally;
        return res;
    endfunction

    // Most keys come from a small pool so that lookups hit often.
    function automatic logic [ROT_KEY_BITS-1:0] pick_key();
        if ($urandom_range(99) < 85) begin
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [ROT_KIND_BITS-1:0] random_kind();
        return ROT_KIND_BITS'($urandom_range(0, KIND_MAX));
    endfunction

    task automatic send_request(input rot_op_t op, input logic [ROT_KEY_BITS-1:0] key,
                                input logic [ROT_KIND_BITS-1:0] kind,
                                input logic [ROT_NUM_BITS-1:0] num);
        rot_in_t req;
        int gap;
        gap = 0;
        if (send_idle_pct > 0) begin
            // Now and then a long gap, so that idle time lands anywhere in a scan.
            if ($urandom_range(99) < 8) begin
                gap = $urandom_range(1, 300);
            end else begin
                while ($urandom_range(99) < send_idle_pct) begin
                    gap++;
                end
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.opcode = op;
        req.resource_key = key;
        req.owner_kind = kind;
        req.owner_number = num;
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_table_op(req));
        requests_sent++;
    endtask

    // Holds the sender off until every outstanding result has been checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic write_enable(input logic value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        table_enabled = value;
    endtask

    task automatic send_random_request();
        rot_op_t op;
        int roll;
        int hit;
        logic [ROT_KEY_BITS-1:0] key;
        logic [ROT_KIND_BITS-1:0] kind;
        logic [ROT_NUM_BITS-1:0] num;
        roll = $urandom_range(99);
        if (roll < 35) begin
            op = OP_REGISTER;
        end else if (roll < 55) begin
            op = OP_TRANSFER;
        end else if (roll < 75) begin
            op = OP_UNREGISTER;
        end else begin
            op = OP_VERIFY;
        end
        key = pick_key();
        kind = random_kind();
        num = $urandom();
        hit = lowest_slot_with_key(key);
        if (op == OP_VERIFY && hit >= 0 && $urandom_range(99) < 60) begin
            kind = slot_kind[hit];
            num = slot_num[hit];
            // Near misses: one bit off in the kind or the number.
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(1)) begin
                    kind = kind ^ ROT_KIND_BITS'(1 << $urandom_range(ROT_KIND_BITS - 1));
                end else begin
                    num = num ^ (32'd1 << $urandom_range(ROT_NUM_BITS - 1));
                end
            end
        end
        send_request(op, key, kind, num);
    endtask

    task automatic test_disabled_ops();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_request(OP_REGISTER, '1, '1, '1);
        send_request(OP_TRANSFER, '0, '0, '0);
        send_request(OP_UNREGISTER, '1, '0, '1);
        send_request(OP_VERIFY, '0, '1, '0);
        wait_for_results();
    endtask

    task automatic test_basic_ownership();
        send_request(OP_REGISTER, '0, '0, '0);
        send_request(OP_REGISTER, '1, '1, '1);
        send_request(OP_VERIFY, '0, '0, '0);
        send_request(OP_VERIFY, '1, '1, '1);
        send_request(OP_VERIFY, '1, ROT_KIND_BITS'(KIND_MAX - 1), '1);
        send_request(OP_TRANSFER, '1, 4'h5, 32'hA5A5_5A5A);
        send_request(OP_VERIFY, '1, 4'h5, 32'hA5A5_5A5A);
        send_request(OP_UNREGISTER, '0, '0, '0);
        send_request(OP_UNREGISTER, '0, '0, '0);
        send_request(OP_TRANSFER, '0, 4'h3, 32'h1);
        send_request(OP_VERIFY, '0, '0, '0);
        send_request(OP_UNREGISTER, '1, '0, '0);
        wait_for_results();
    endtask

    // Two entries with the same key: lookups act on the lower slot.
    task automatic test_duplicate_keys();
        send_request(OP_REGISTER, 32'h0000_BEEF, 4'h1, 32'd100);
        send_request(OP_REGISTER, 32'h0000_BEEF, 4'h2, 32'd200);
        send_request(OP_VERIFY, 32'h0000_BEEF, 4'h2, 32'd200);
        send_request(OP_UNREGISTER, 32'h0000_BEEF, 4'h0, 32'd0);
        send_request(OP_VERIFY, 32'h0000_BEEF, 4'h2, 32'd200);
        send_request(OP_UNREGISTER, 32'h0000_BEEF, 4'h0, 32'd0);
        wait_for_results();
    endtask

    // Disabling must keep both the table contents and the counter.
    task automatic test_enable_toggle();
        send_request(OP_REGISTER, 32'h1234_5678, 4'h3, 32'd33);
        write_enable(1'b0);
        send_request(OP_VERIFY, 32'h1234_5678, 4'h3, 32'd33);
        send_request(OP_TRANSFER, 32'h8765_4321, 4'h3, 32'd33);
        write_enable(1'b1);
        send_request(OP_VERIFY, 32'h1234_5678, 4'h3, 32'd33);
        send_request(OP_UNREGISTER, 32'h1234_5678, 4'h0, 32'd0);
        wait_for_results();
    endtask

    // Expects an empty table on entry and leaves it empty.
    task automatic test_table_full();
        logic [ROT_KEY_BITS-1:0] held_keys[$];
        logic [ROT_KEY_BITS-1:0] key;
        int hit;
        send_idle_pct = 25;
        recv_stall_pct = 25;
        repeat (ROT_ENTRIES) begin
            key = pick_key();
            held_keys.push_back(key);
            send_request(OP_REGISTER, key, random_kind(), $urandom());
        end
        repeat (3) send_request(OP_REGISTER, pick_key(), random_kind(), $urandom());
        hit = lowest_slot_with_key(held_keys[0]);
        send_request(OP_VERIFY, held_keys[0], slot_kind[hit], slot_num[hit]);
        send_request(OP_TRANSFER, held_keys[ROT_ENTRIES-1], random_kind(), $urandom());
        // Free one slot; the next register must land there.
        send_request(OP_UNREGISTER, held_keys[100], '0, '0);
        key = $urandom();
        held_keys[100] = key;
        send_request(OP_REGISTER, key, random_kind(), $urandom());
        send_request(OP_REGISTER, pick_key(), random_kind(), $urandom());
        foreach (held_keys[i]) begin
            send_request(OP_UNREGISTER, held_keys[i], random_kind(), $urandom());
        end
        wait_for_results();
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                write_enable(1'b0);
                repeat (4) send_random_request();
                write_enable(1'b1);
            end else if ($urandom_range(99) < 2) begin
                wait_for_results();
            end
            send_random_request();
        end
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d match %0d count %0d",
                         $time, m_data.status, m_data.owner_match, m_data.violations);
                mismatch_count++;
            end else begin
                oldest_expected = expected_results.pop_front();
                results_checked++;
                status_seen[m_data.status]++;
                if (m_data.status !== oldest_expected.status ||
                    m_data.owner_match !== oldest_expected.owner_match ||
                    m_data.violations !== oldest_expected.violations) begin
                    $display("%0t: mismatch: expected status %0d match %0d count %0d",
                             $time, oldest_expected.status, oldest_expected.owner_match,
                             oldest_expected.violations);
                    $display("%0t: mismatch: actual   status %0d match %0d count %0d",
                             $time, m_data.status, m_data.owner_match, m_data.violations);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        requests_sent = 0;
        results_checked = 0;
        table_enabled = 1'b0;
        violation_tally = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_ops();
        write_enable(1'b1);
        test_basic_ownership();
        test_duplicate_keys();
        test_enable_toggle();
        test_table_full();
        run_random_phase(170, 0, 0);
        run_random_phase(170, 67, 0);
        run_random_phase(170, 0, 67);
        run_random_phase(170, 25, 25);

        wait_for_results();
        repeat (ROT_ENTRIES + 8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_count++;
        end
        $display("Covered %0d requests and %0d results across directed and paced random tests.",
                 requests_sent, results_checked);
        $display("Status mix: ok %0d, disabled %0d, full %0d, missing %0d; %0d errors.",
                 status_seen[ST_OK], status_seen[ST_DISABLED], status_seen[ST_FULL],
                 status_seen[ST_MISSING], mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
